[hdl/cle_pkg.sv]
// shared types and constants of the console line editor
package cle_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;

    localparam logic [BYTE_W-1:0] RETURN_CODE_RESET = 8'd13;
    localparam logic [BYTE_W-1:0] KEY_ESC           = 8'd27;
    localparam logic [BYTE_W-1:0] KEY_BACKSPACE     = 8'd127;
    localparam logic [BYTE_W-1:0] FIRST_PRINTABLE   = 8'd32;
    localparam logic [BYTE_W-1:0] KEY_LBRACKET      = 8'h5B;
    localparam logic [BYTE_W-1:0] KEY_LEFT          = 8'h44;
    localparam logic [BYTE_W-1:0] KEY_RIGHT         = 8'h43;
    localparam logic [BYTE_W-1:0] KEY_UP            = 8'h41;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_LINE_BYTE  = 3'd1,
        EV_EMPTY_LINE = 3'd2,
        EV_REDRAW     = 3'd3,
        EV_HISTORY_UP = 3'd4
    } t_event_kind;

    typedef enum logic [0:0] {
        CFG_RETURN_CODE    = 1'b0,
        CFG_HISTORY_ENABLE = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_SHIFT  = 2'd2,
        S_EMIT   = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        ESC_NORMAL  = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } t_esc_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] return_code;
        logic              history_enable;
    } t_cfg;

    typedef struct packed {
        t_event_kind       kind;
        logic [BYTE_W-1:0] line_char;
        logic              last;
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  line_length;
    } t_result;

endpackage

[hdl/console_line_editor_unit.sv]
// console line editor top level: config registers, line store, sequencer
//
// channel  | dir | beat contents
// s_axis   | in  | tdata[7:0] rx_byte
// m_axis   | out | tdata line_char/cursor_pos/line_length, tuser event_kind, tlast
// i_cfg_*  | in  | index 0 return_code, index 1 history_enable
//
// a plain byte, an escape byte or a backspace at cursor 0 is taken in idle and answered from decode
// any other backspace moves each entry after the cursor down one place in the shift state, then reports a redraw
// a submit reads the line out in the emit state, one beat per cycle once the first read is back, unless output stalls
// an output stall holds the sequencer where it must push a result; one result beat can wait while the next byte arrives
// reset clears cursor, length and escape phase; the line store needs no clearing
module console_line_editor_unit #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] line_char, [13:8] cursor_pos, [19:14] line_length
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int W_IDX = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    logic [cle_pkg::BYTE_W-1:0] r_return_code;
    logic                       r_history_enable;
    cle_pkg::t_cfg              cfg;
    cle_pkg::t_result           res;

    logic                       ram_we;
    logic [W_IDX-1:0]           ram_waddr;
    logic [cle_pkg::BYTE_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [W_IDX-1:0]           ram_raddr;
    logic [cle_pkg::BYTE_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_return_code    <= cle_pkg::RETURN_CODE_RESET;
            r_history_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (cle_pkg::t_cfg_index'(i_cfg_index))
                cle_pkg::CFG_RETURN_CODE:    r_return_code    <= i_cfg_data;
                cle_pkg::CFG_HISTORY_ENABLE: r_history_enable <= i_cfg_data[0];
            endcase
        end
    end

    assign cfg.return_code    = r_return_code;
    assign cfg.history_enable = r_history_enable;

    cle_line_ram #(
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cle_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    assign m_axis_tdata = {4'b0000, res.line_length, res.cursor_pos, res.line_char};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.kind;

endmodule

[hdl/cle_line_ram.sv]
// line store: one write port, one read port with registered read data
module cle_line_ram #(
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [cle_pkg::BYTE_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [cle_pkg::BYTE_W-1:0]  o_rdata
);

    logic [cle_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [cle_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/cle_ctrl.sv]
// line editor sequencer: decode, backspace shift, line emit, result register
module cle_ctrl #(
    parameter  int LINE_CAPACITY = 32,
    localparam int W_IDX         = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cle_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [cle_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cle_pkg::t_result            o_out,
    output logic                        o_ram_we,
    output logic [W_IDX-1:0]            o_ram_waddr,
    output logic [cle_pkg::BYTE_W-1:0]  o_ram_wdata,
    output logic                        o_ram_re,
    output logic [W_IDX-1:0]            o_ram_raddr,
    input  logic [cle_pkg::BYTE_W-1:0]  i_ram_rdata
);

    localparam int W_CNT = $clog2(LINE_CAPACITY + 1);
    localparam logic [W_CNT-1:0] CAP = W_CNT'(LINE_CAPACITY);
    localparam logic [W_CNT-1:0] ONE = W_CNT'(1);

    cle_pkg::t_state     r_state, n_state;
    cle_pkg::t_esc_phase r_esc, n_esc;
    logic [W_CNT-1:0]    r_cursor, n_cursor;
    logic [W_CNT-1:0]    r_fill, n_fill;
    logic [W_CNT-1:0]    r_idx, n_idx;
    logic [W_IDX-1:0]    r_waddr, n_waddr;
    logic                r_pend, n_pend;
    logic [cle_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic                r_out_valid, n_out_valid;
    cle_pkg::t_result    r_out, n_out;

    logic                slot_free;
    logic                push;
    logic                res_emit;
    logic                res_last;
    cle_pkg::t_event_kind res_kind;
    logic [W_CNT-1:0]    cur_inc;
    logic [W_CNT-1:0]    idx_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_esc       <= cle_pkg::ESC_NORMAL;
            r_cursor    <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_esc       <= n_esc;
            r_cursor    <= n_cursor;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_waddr <= n_waddr;
        r_byte  <= n_byte;
        r_out   <= n_out;
    end

    assign slot_free = !r_out_valid || i_out_ready;
    assign cur_inc   = r_cursor + ONE;
    assign idx_inc   = r_idx + ONE;

    always_comb begin
        n_state     = r_state;
        n_esc       = r_esc;
        n_cursor    = r_cursor;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_waddr     = r_waddr;
        n_pend      = r_pend;
        n_byte      = r_byte;
        push        = 1'b0;
        res_emit    = 1'b0;
        res_last    = 1'b1;
        res_kind    = cle_pkg::EV_NONE;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cursor[W_IDX-1:0];
        o_ram_wdata = r_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx[W_IDX-1:0];

        unique case (r_state)
            cle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_in_byte;
                    n_state = cle_pkg::S_DECODE;
                end
            end
            cle_pkg::S_DECODE: begin
                if (slot_free) begin
                    n_state = cle_pkg::S_IDLE;
                    n_esc   = cle_pkg::ESC_NORMAL;
                    unique case (r_esc)
                        cle_pkg::ESC_SEEN: begin
                            if (r_byte == cle_pkg::KEY_LBRACKET) begin
                                n_esc = cle_pkg::ESC_BRACKET;
                            end
                            push = 1'b1;
                        end
                        cle_pkg::ESC_BRACKET: begin
                            if (r_byte == cle_pkg::KEY_LEFT) begin
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - ONE;
                                end
                            end else if (r_byte == cle_pkg::KEY_RIGHT) begin
                                if (r_cursor < r_fill) begin
                                    n_cursor = cur_inc;
                                end
                            end else if (r_byte == cle_pkg::KEY_UP) begin
                                if (i_cfg.history_enable) begin
                                    res_kind = cle_pkg::EV_HISTORY_UP;
                                end
                            end
                            push = 1'b1;
                        end
                        default: begin
                            // return code is tested before any other byte class
                            if (r_byte == i_cfg.return_code) begin
                                n_cursor = '0;
                                if (r_fill == '0) begin
                                    res_kind = cle_pkg::EV_EMPTY_LINE;
                                    push     = 1'b1;
                                end else begin
                                    o_ram_re    = 1'b1;
                                    o_ram_raddr = '0;
                                    n_idx       = '0;
                                    n_state     = cle_pkg::S_EMIT;
                                end
                            end else if (r_byte == cle_pkg::KEY_ESC) begin
                                n_esc = cle_pkg::ESC_SEEN;
                                push  = 1'b1;
                            end else if (r_byte == cle_pkg::KEY_BACKSPACE) begin
                                if (r_cursor != '0) begin
                                    n_idx   = r_cursor;
                                    n_pend  = 1'b0;
                                    n_state = cle_pkg::S_SHIFT;
                                end else begin
                                    res_kind = cle_pkg::EV_REDRAW;
                                    push     = 1'b1;
                                end
                            end else begin
                                if (r_byte >= cle_pkg::FIRST_PRINTABLE && r_cursor < CAP) begin
                                    o_ram_we = 1'b1;
                                    n_cursor = cur_inc;
                                    if (cur_inc > r_fill) begin
                                        n_fill = cur_inc;
                                    end
                                end
                                push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            cle_pkg::S_SHIFT: begin
                // read entry idx while the entry read a beat earlier lands one below it
                if (r_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_waddr;
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_idx < r_fill) begin
                    o_ram_re = 1'b1;
                    n_waddr  = W_IDX'(r_idx - ONE);
                    n_idx    = idx_inc;
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend && slot_free) begin
                        n_cursor = r_cursor - ONE;
                        n_fill   = r_fill - ONE;
                        res_kind = cle_pkg::EV_REDRAW;
                        push     = 1'b1;
                        n_state  = cle_pkg::S_IDLE;
                    end
                end
            end
            cle_pkg::S_EMIT: begin
                if (slot_free) begin
                    push     = 1'b1;
                    res_emit = 1'b1;
                    res_kind = cle_pkg::EV_LINE_BYTE;
                    res_last = (idx_inc == r_fill);
                    if (res_last) begin
                        n_fill  = '0;
                        n_state = cle_pkg::S_IDLE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = idx_inc[W_IDX-1:0];
                        n_idx       = idx_inc;
                    end
                end
            end
            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (push) begin
            n_out_valid       = 1'b1;
            n_out.kind        = res_kind;
            n_out.line_char   = res_emit ? i_ram_rdata : '0;
            n_out.last        = res_last;
            n_out.cursor_pos  = res_emit ? '0 : cle_pkg::POS_W'(n_cursor);
            n_out.line_length = res_emit ? cle_pkg::POS_W'(r_fill) : cle_pkg::POS_W'(n_fill);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == cle_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP)
        else $error("line length above capacity");

    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_fill)
        else $error("cursor past end of line");

    a_emit_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cle_pkg::S_EMIT) |-> !o_ram_we)
        else $error("line store written during emit");

    a_emit_ends_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_state == cle_pkg::S_EMIT && res_last)
        |=> (r_state == cle_pkg::S_IDLE && r_fill == '0 && r_cursor == '0))
        else $error("line not cleared after final byte");

endmodule

[tb/tb_top.sv]
// testbench for the console line editor: directed and random key streams, checked beat by beat
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_CAP = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] line_char, [13:8] cursor_pos, [19:14] line_length
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;         // [2:0] event_kind
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    console_line_editor_unit #(
        .LINE_CAPACITY(LINE_CAP)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // keys waiting to be sent and beats the editor still owes us
    logic [7:0]       key_queue [$];
    cle_pkg::t_result want_beats [$];
    int               error_count = 0;
    int               send_idle_pct = 29;
    int               recv_idle_pct = 87;

    // model copy of the editor
    logic [7:0]          ed_line [LINE_CAP];
    int                  ed_cursor = 0;
    int                  ed_length = 0;
    cle_pkg::t_esc_phase ed_phase = cle_pkg::ESC_NORMAL;
    logic [7:0]          cfg_return = cle_pkg::RETURN_CODE_RESET;
    logic                cfg_history = 1'b0;

    function automatic cle_pkg::t_result make_beat(cle_pkg::t_event_kind k, logic [7:0] ch,
                                                   logic lst, int cur, int len);
        cle_pkg::t_result r;
        r.kind        = k;
        r.line_char   = ch;
        r.last        = lst;
        r.cursor_pos  = cle_pkg::POS_W'(cur);
        r.line_length = cle_pkg::POS_W'(len);
        return r;
    endfunction

    task automatic edit_console_line(input logic [7:0] key);
        cle_pkg::t_event_kind ev;
        ev = cle_pkg::EV_NONE;
        case (ed_phase)
            cle_pkg::ESC_SEEN: begin
                ed_phase = (key == cle_pkg::KEY_LBRACKET) ? cle_pkg::ESC_BRACKET
                                                          : cle_pkg::ESC_NORMAL;
            end
            cle_pkg::ESC_BRACKET: begin
                if (key == cle_pkg::KEY_LEFT) begin
                    if (ed_cursor > 0) ed_cursor--;
                end else if (key == cle_pkg::KEY_RIGHT) begin
                    if (ed_cursor < ed_length) ed_cursor++;
                end else if (key == cle_pkg::KEY_UP && cfg_history) begin
                    ev = cle_pkg::EV_HISTORY_UP;
                end
                ed_phase = cle_pkg::ESC_NORMAL;
            end
            default: begin
                ed_phase = cle_pkg::ESC_NORMAL;
                if (key == cfg_return) begin
                    // submit: whole line out, then cleared
                    if (ed_length == 0) begin
                        want_beats.push_back(make_beat(cle_pkg::EV_EMPTY_LINE, '0, 1'b1,
                                                       0, 0));
                    end else begin
                        for (int i = 0; i < ed_length; i++)
                            want_beats.push_back(make_beat(cle_pkg::EV_LINE_BYTE, ed_line[i],
                                                           i == ed_length - 1, 0, ed_length));
                    end
                    ed_cursor = 0;
                    ed_length = 0;
                    return;
                end else if (key == cle_pkg::KEY_ESC) begin
                    ed_phase = cle_pkg::ESC_SEEN;
                end else if (key == cle_pkg::KEY_BACKSPACE) begin
                    if (ed_cursor > 0) begin
                        for (int i = ed_cursor; i < ed_length; i++)
                            ed_line[i-1] = ed_line[i];
                        ed_cursor--;
                        ed_length--;
                    end
                    ev = cle_pkg::EV_REDRAW;
                end else if (key >= cle_pkg::FIRST_PRINTABLE && ed_cursor < LINE_CAP) begin
                    ed_line[ed_cursor] = key;
                    ed_cursor++;
                    if (ed_cursor > ed_length) ed_length = ed_cursor;
                end
            end
        endcase
        want_beats.push_back(make_beat(ev, '0, 1'b1, ed_cursor, ed_length));
    endtask

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // key driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) edit_console_line(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (key_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= key_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    cle_pkg::t_result want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_beats.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat tuser %0d tdata %h",
                                            m_axis_tuser, m_axis_tdata));
                end else begin
                    want = want_beats.pop_front();
                    if (m_axis_tuser !== want.kind)
                        flag_mismatch($sformatf("event_kind %0d, want %0d",
                                                m_axis_tuser, want.kind));
                    if (m_axis_tdata[7:0] !== want.line_char)
                        flag_mismatch($sformatf("line_char %h, want %h",
                                                m_axis_tdata[7:0], want.line_char));
                    if (m_axis_tlast !== want.last)
                        flag_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
                    if (m_axis_tdata[13:8] !== want.cursor_pos)
                        flag_mismatch($sformatf("cursor_pos %0d, want %0d",
                                                m_axis_tdata[13:8], want.cursor_pos));
                    if (m_axis_tdata[19:14] !== want.line_length)
                        flag_mismatch($sformatf("line_length %0d, want %0d",
                                                m_axis_tdata[19:14], want.line_length));
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cle_pkg::t_cfg_index idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cle_pkg::CFG_RETURN_CODE) cfg_return = val;
        else cfg_history = val[0];
    endtask

    // hold off until every key is in and every owed beat is out
    task automatic drain();
        do @(posedge i_clk);
        while (key_queue.size() != 0 || s_axis_tvalid || want_beats.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [7:0] printable_key();
        logic [7:0] k;
        do k = 8'($urandom_range(255, 32));
        while (k == cle_pkg::KEY_BACKSPACE || k == cfg_return);
        return k;
    endfunction

    task automatic add_random_keys(input int goal);
        int made;
        int pick;
        int n;
        made = 0;
        while (made < goal) begin
            pick = $urandom_range(99, 0);
            if (pick < 35) begin
                // typing, now and then long enough to hit a full line
                n = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
                repeat (n) key_queue.push_back(printable_key());
                made += n;
            end else if (pick < 50) begin
                key_queue.push_back(cle_pkg::KEY_ESC);
                key_queue.push_back(cle_pkg::KEY_LBRACKET);
                case ($urandom_range(4, 0))
                    0, 1:    key_queue.push_back(cle_pkg::KEY_LEFT);
                    2, 3:    key_queue.push_back(cle_pkg::KEY_RIGHT);
                    default: key_queue.push_back(cle_pkg::KEY_UP);
                endcase
                made += 3;
            end else if (pick < 60) begin
                n = $urandom_range(3, 1);
                repeat (n) key_queue.push_back(cle_pkg::KEY_BACKSPACE);
                made += n;
            end else if (pick < 73) begin
                key_queue.push_back(cfg_return);
                made += 1;
            end else if (pick < 85) begin
                // broken escape sequences
                key_queue.push_back(cle_pkg::KEY_ESC);
                case ($urandom_range(2, 0))
                    0: key_queue.push_back(8'($urandom_range(255, 0)));
                    1: begin
                        key_queue.push_back(cle_pkg::KEY_LBRACKET);
                        key_queue.push_back(8'($urandom_range(255, 0)));
                    end
                    default: key_queue.push_back(cfg_return);
                endcase
                made += 3;
            end else begin
                key_queue.push_back(8'($urandom_range(255, 0)));
                made += 1;
            end
        end
    endtask

    logic [7:0] phase_return [8];
    logic       phase_history [8];

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(cle_pkg::CFG_RETURN_CODE, cle_pkg::RETURN_CODE_RESET);
        write_reg(cle_pkg::CFG_HISTORY_ENABLE, 8'd1);

        // empty submit, typing with high bytes, edits at both ends, escapes, submit
        key_queue = '{cle_pkg::RETURN_CODE_RESET, cle_pkg::FIRST_PRINTABLE, 8'hFF, 8'h7E,
                      cle_pkg::KEY_BACKSPACE,
                      cle_pkg::KEY_ESC, cle_pkg::KEY_LBRACKET, cle_pkg::KEY_RIGHT,
                      cle_pkg::KEY_ESC, cle_pkg::KEY_LBRACKET, cle_pkg::KEY_LEFT,
                      cle_pkg::KEY_BACKSPACE, cle_pkg::KEY_BACKSPACE,
                      cle_pkg::KEY_ESC, cle_pkg::KEY_LBRACKET, cle_pkg::KEY_LEFT,
                      cle_pkg::KEY_ESC, cle_pkg::KEY_LBRACKET, cle_pkg::KEY_UP,
                      cle_pkg::KEY_ESC, 8'h78,
                      cle_pkg::KEY_ESC, cle_pkg::KEY_LBRACKET, 8'h7A,
                      8'h00, cle_pkg::RETURN_CODE_RESET};
        drain();

        phase_return  = '{cle_pkg::RETURN_CODE_RESET, 8'h00, 8'hFF, cle_pkg::KEY_ESC,
                          cle_pkg::KEY_BACKSPACE, cle_pkg::KEY_LBRACKET,
                          8'($urandom_range(126, 33)), cle_pkg::RETURN_CODE_RESET};
        phase_history = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom_range(1, 0))};

        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 87;
            end else if (p < 6) begin
                send_idle_pct = 87;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(cle_pkg::CFG_RETURN_CODE, phase_return[p]);
            write_reg(cle_pkg::CFG_HISTORY_ENABLE, {7'd0, phase_history[p]});
            add_random_keys(34);
            drain();
        end

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
